[rtl/phe_pkg.sv]
package phe_pkg;

  // Highest power of the argument that the pipeline evaluates (1 to 7).
  localparam int DEGREE     = 7;
  localparam int NUM_COEF   = 8;
  localparam int COEF_IDX_W = 3;
  localparam int Q_W        = 32;
  localparam int FRAC_W     = 16;
  localparam int PROD_W     = 2 * Q_W;
  localparam int RND_W      = PROD_W - FRAC_W;
  localparam int SUM_W      = RND_W + 1;

  localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) <<< (FRAC_W - 1);
  localparam logic signed [SUM_W-1:0]  SUM_MAX    = SUM_W'(64'sd2147483647);
  localparam logic signed [SUM_W-1:0]  SUM_MIN    = -SUM_W'(64'sd2147483648);
  localparam logic signed [Q_W-1:0]    Q_MAX      = 32'sh7fff_ffff;
  localparam logic signed [Q_W-1:0]    Q_MIN      = 32'sh8000_0000;

  typedef logic signed [Q_W-1:0]  q_t;
  typedef logic [COEF_IDX_W-1:0]  coef_idx_t;
  typedef q_t                     coef_arr_t [NUM_COEF];

  // One Horner step's worth of data travelling between cells.
  typedef struct packed {
    logic valid;
    q_t   arg;
    q_t   acc;
    logic sat;
  } stage_t;

endpackage

[rtl/phe_arg_if.sv]
interface phe_arg_if;
  import phe_pkg::*;

  logic valid;
  logic ready;
  q_t   argument;

  modport source (output valid, output argument, input ready);
  modport sink   (input valid, input argument, output ready);
endinterface

[rtl/phe_res_if.sv]
interface phe_res_if;
  import phe_pkg::*;

  logic valid;
  logic ready;
  q_t   value;
  logic saturated;

  modport source (output valid, output value, output saturated, input ready);
  modport sink   (input valid, input value, input saturated, output ready);
endinterface

[rtl/phe_coef_bank.sv]
module phe_coef_bank (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                we_i,
  input  phe_pkg::coef_idx_t  idx_i,
  input  phe_pkg::q_t         data_i,
  output phe_pkg::coef_arr_t  coef_o
);
  import phe_pkg::*;

  q_t coef_q [NUM_COEF];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_COEF; k++) begin
        coef_q[k] <= '0;
      end
    end else if (we_i) begin
      coef_q[idx_i] <= data_i;
    end
  end

  assign coef_o = coef_q;

endmodule

[rtl/phe_cell.sv]
module phe_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  phe_pkg::q_t     coef_i,
  input  phe_pkg::stage_t up_i,
  output logic            up_ready_o,
  output phe_pkg::stage_t dn_o,
  input  logic            dn_ready_i
);
  import phe_pkg::*;

  // First half: the exact product. Second half: round, add, clip.
  logic                     v1_q;
  logic signed [PROD_W-1:0] prod_q, prod_d;
  q_t                       arg1_q;
  logic                     sat1_q;

  stage_t                   st2_q, st2_d;

  logic                     en1, en2;
  logic signed [PROD_W-1:0] rnd;
  logic signed [RND_W-1:0]  rnd_hi;
  logic signed [SUM_W-1:0]  sum;

  // A stage moves when it is empty or its successor moves.
  assign en2        = !st2_q.valid || dn_ready_i;
  assign en1        = !v1_q || en2;
  assign up_ready_o = en1;

  assign prod_d = up_i.acc * up_i.arg;

  always_comb begin
    rnd    = prod_q + ROUND_HALF;
    rnd_hi = rnd[PROD_W-1:FRAC_W];
    sum    = SUM_W'(rnd_hi) + SUM_W'(coef_i);
    st2_d.valid = v1_q;
    st2_d.arg   = arg1_q;
    st2_d.sat   = sat1_q;
    st2_d.acc   = sum[Q_W-1:0];
    if (sum > SUM_MAX) begin
      st2_d.acc = Q_MAX;
      st2_d.sat = 1'b1;
    end else if (sum < SUM_MIN) begin
      st2_d.acc = Q_MIN;
      st2_d.sat = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      st2_q <= '0;
    end else begin
      if (en1) v1_q  <= up_i.valid;
      if (en2) st2_q <= st2_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      prod_q <= prod_d;
      arg1_q <= up_i.arg;
      sat1_q <= up_i.sat;
    end
  end

  assign dn_o = st2_q;

`ifndef NO_ASSERTIONS
  a_stall_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    st2_q.valid && !dn_ready_i |=> st2_q.valid && $stable(st2_q.acc) && $stable(st2_q.sat))
    else $error("stalled cell output changed");

  a_sat_sticky : assert property (@(posedge clk_i) disable iff (!rst_ni)
    en2 && v1_q && sat1_q |=> st2_q.sat)
    else $error("saturation flag lost in cell");

  a_sat_extreme : assert property (@(posedge clk_i) disable iff (!rst_ni)
    en2 && v1_q && !sat1_q |=> !st2_q.sat || st2_q.acc == Q_MAX || st2_q.acc == Q_MIN)
    else $error("saturation flagged without clipped value");

  a_empty_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v1_q && !st2_q.valid |-> up_ready_o)
    else $error("empty cell refused a request");
`endif

endmodule

[rtl/polynomial_horner_evaluator_top.sv]
// Horner polynomial evaluator, signed Q16.16. Each request on arg_i carries one argument x;
// the result on res_o is p(x) = coef_DEGREE * x^DEGREE + ... + coef_0, with every Horner step
// rounded to nearest (half toward plus infinity) and clipped to the 32-bit range, and
// 'saturated' set if any step clipped. The block takes one request per clock cycle while the
// pipeline has room, and delivers results in order: the pipeline is a row of DEGREE identical
// cells, one per Horner step, each registering first the 32 x 32 product and then the result
// of rounding, adding the coefficient and clipping. Each stage moves independently when its
// successor has room, so bubbles close up and new requests are still taken while a finished
// result waits on res_o, until the pipeline fills. Coefficients are written through the
// cfg port (index k sets the coefficient of x^k, reset value zero) and must only change
// while no request is in flight; a lower degree is obtained by zeroing the high coefficients.
module polynomial_horner_evaluator_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  phe_pkg::coef_idx_t cfg_idx_i,
  input  phe_pkg::q_t        cfg_data_i,
  phe_arg_if.sink            arg_i,
  phe_res_if.source          res_o
);
  import phe_pkg::*;

  coef_arr_t coef;
  stage_t    chain [DEGREE+1];
  logic      rdy   [DEGREE+1];

  phe_coef_bank u_coef_bank (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (cfg_we_i),
    .idx_i  (cfg_idx_i),
    .data_i (cfg_data_i),
    .coef_o (coef)
  );

  // The accumulator starts at the highest coefficient; the saturation flag starts clear.
  always_comb begin
    chain[0].valid = arg_i.valid;
    chain[0].arg   = arg_i.argument;
    chain[0].acc   = coef[COEF_IDX_W'(DEGREE)];
    chain[0].sat   = 1'b0;
  end
  assign arg_i.ready = rdy[0];

  // Cell i multiplies by x and adds coef_(DEGREE-1-i).
  for (genvar i = 0; i < DEGREE; i++) begin : g_cell
    phe_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .coef_i     (coef[COEF_IDX_W'(DEGREE - 1 - i)]),
      .up_i       (chain[i]),
      .up_ready_o (rdy[i]),
      .dn_o       (chain[i+1]),
      .dn_ready_i (rdy[i+1])
    );
  end

  // The last cell's output register is the result register.
  assign rdy[DEGREE]     = res_o.ready;
  assign res_o.valid     = chain[DEGREE].valid;
  assign res_o.value     = chain[DEGREE].acc;
  assign res_o.saturated = chain[DEGREE].sat;

endmodule

[verif/phe_result_checker.sv]
// Watches the coefficient port and both channels, predicts each result from its own copy of
// the coefficients and compares the results that come out, in order, field by field.
module phe_result_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  phe_pkg::coef_idx_t cfg_idx_i,
  input  phe_pkg::q_t        cfg_data_i,
  phe_arg_if                 arg_mon,
  phe_res_if                 res_mon,
  output int                 fail_count_o,
  output int                 pending_o
);
  import phe_pkg::*;

  // A degree outside 1..7 wraps modulo eight.
  localparam int TOP_POWER = DEGREE % 8;

  typedef struct packed {
    q_t   value;
    logic saturated;
  } poly_result_t;

  q_t           coef_q [NUM_COEF];
  poly_result_t expected_q [$];
  int           fails = 0;

  // Horner's rule at Q16.16: exact product, round half up, add, clip to 32 bits.
  function automatic poly_result_t horner_eval(input q_t x);
    longint       acc;
    longint       prod;
    longint       sum;
    poly_result_t res;
    acc           = longint'(coef_q[TOP_POWER]);
    res.saturated = 1'b0;
    for (int k = TOP_POWER - 1; k >= 0; k--) begin
      prod = acc * longint'(x);
      sum  = ((prod + 64'sd32768) >>> 16) + longint'(coef_q[k]);
      if (sum > longint'(Q_MAX)) begin
        sum           = longint'(Q_MAX);
        res.saturated = 1'b1;
      end else if (sum < longint'(Q_MIN)) begin
        sum           = longint'(Q_MIN);
        res.saturated = 1'b1;
      end
      acc = sum;
    end
    res.value = acc[Q_W-1:0];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    poly_result_t want;
    if (!rst_ni) begin
      for (int k = 0; k < NUM_COEF; k++) coef_q[k] <= '0;
      expected_q.delete();
      pending_o    <= 0;
      fail_count_o <= fails;
    end else begin
      if (cfg_we_i) begin
        coef_q[cfg_idx_i] <= cfg_data_i;
      end
      if (arg_mon.valid && arg_mon.ready) begin
        expected_q.push_back(horner_eval(arg_mon.argument));
      end
      if (res_mon.valid && res_mon.ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got value %h saturated %b",
                   $time, res_mon.value, res_mon.saturated);
          fails++;
        end else begin
          want = expected_q.pop_front();
          if (res_mon.value !== want.value) begin
            $display("%0t: value mismatch, expected %h, got %h",
                     $time, want.value, res_mon.value);
            fails++;
          end
          if (res_mon.saturated !== want.saturated) begin
            $display("%0t: saturated mismatch, expected %b, got %b",
                     $time, want.saturated, res_mon.saturated);
            fails++;
          end
        end
      end
      pending_o    <= expected_q.size();
      fail_count_o <= fails;
    end
  end

endmodule

[verif/polynomial_horner_evaluator_top_test.sv]
// Top of the evaluator testbench. It only makes stimulus and gives the verdict; the checker
// beside the block predicts every result and counts the failures.
module polynomial_horner_evaluator_top_test;
  import phe_pkg::*;

  // Number of pipeline registers a request passes through.
  localparam int PIPE_LATENCY  = 2 * DEGREE;
  // The random part runs through this many coefficient settings; the last one has no idling.
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 104;
  // One and one half in Q16.16.
  localparam q_t ONE           = 32'sh0001_0000;
  localparam q_t HALF          = 32'sh0000_8000;

  logic      clk_i;
  logic      rst_ni;
  logic      cfg_we;
  coef_idx_t cfg_idx;
  q_t        cfg_data;
  int        fail_count;
  int        pending;
  bit        calm_tail;

  phe_arg_if arg_if ();
  phe_res_if res_if ();

  polynomial_horner_evaluator_top DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .arg_i      (arg_if),
    .res_o      (res_if)
  );

  phe_result_checker result_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .arg_mon      (arg_if),
    .res_mon      (res_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Safety net: even the slowest correct run finishes far earlier than this.
  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // The result side stalls in random bursts, except in the calm tail of the run.
  // Each step assigns ready exactly once.
  initial begin : result_stalls
    int stall;
    stall = 0;
    res_if.ready <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (stall > 0) begin
        stall--;
        res_if.ready <= 1'b0;
      end else if (!calm_tail && $urandom_range(0, 7) == 0) begin
        stall = $urandom_range(1, 14) - 1;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // Writes all eight coefficients, one per cycle. Only called with the pipeline empty.
  task automatic load_coefs(input coef_arr_t c);
    for (int k = 0; k < NUM_COEF; k++) begin
      @(posedge clk_i);
      cfg_we   <= 1'b1;
      cfg_idx  <= coef_idx_t'(k);
      cfg_data <= c[k];
    end
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // Offers one argument and returns at the edge where the request is accepted. Valid stays
  // high into the next request unless a random gap is taken first, so valid is never dropped
  // and raised within the same step.
  task automatic send_arg(input q_t x);
    if (!calm_tail && $urandom_range(0, 5) == 0) begin
      arg_if.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    arg_if.valid    <= 1'b1;
    arg_if.argument <= x;
    do @(posedge clk_i); while (!arg_if.ready);
  endtask

  // Holds off new requests until every accepted request has produced its result. The count
  // from the checker is read at clock edges, where it reflects all earlier acceptances.
  task automatic drain_results();
    arg_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  function automatic q_t pick_extreme();
    case ($urandom_range(0, 5))
      0:       return Q_MAX;
      1:       return Q_MIN;
      2:       return '0;
      3:       return ONE;
      4:       return -ONE;
      default: return q_t'(1);
    endcase
  endfunction

  // Mostly values within plus or minus two, so that all seven steps carry meaning without
  // clipping; some full-range words and some extremes drive the saturation paths.
  function automatic q_t pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return q_t'(int'($urandom_range(0, 4 * 65536)) - 2 * 65536);
    else if (r < 8) return q_t'($urandom);
    else return pick_extreme();
  endfunction

  // A random polynomial whose effective degree is also random: the coefficients above it
  // are zero.
  function automatic void random_coefs(output coef_arr_t c);
    int top;
    top = $urandom_range(0, 7);
    for (int k = 0; k < NUM_COEF; k++) c[k] = (k > top) ? q_t'(0) : pick_value();
  endfunction

  initial begin : stimulus
    coef_arr_t c;
    rst_ni          <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_idx         <= '0;
    cfg_data        <= '0;
    arg_if.valid    <= 1'b0;
    arg_if.argument <= '0;
    calm_tail        = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Coefficients as they come out of reset: every argument must give zero.
    send_arg('0);
    send_arg(Q_MAX);
    send_arg(Q_MIN);
    drain_results();

    // All coefficients at the positive limit: clipping upward, and alternating clipping for
    // the most negative argument.
    c = '{default: Q_MAX};
    load_coefs(c);
    send_arg(Q_MAX);
    send_arg(Q_MIN);
    send_arg('0);
    send_arg(q_t'(1));
    drain_results();

    // All coefficients at the negative limit, with plus and minus one among the arguments.
    c = '{default: Q_MIN};
    load_coefs(c);
    send_arg(Q_MAX);
    send_arg(Q_MIN);
    send_arg(ONE);
    send_arg(-ONE);
    drain_results();

    // A single least-significant-bit coefficient of x: the rounding of exact halves goes
    // toward plus infinity, and just past a half goes the other way.
    c = '{default: '0};
    c[1] = q_t'(1);
    load_coefs(c);
    send_arg(HALF);
    send_arg(-HALF);
    send_arg(HALF - 1);
    send_arg(-HALF - 1);
    drain_results();

    // An ordinary polynomial of full degree that stays in range.
    c = '{ONE, -HALF, 3 * ONE, -ONE, 32'sh0000_4000, '0, -5, 32'sh0000_2000};
    load_coefs(c);
    send_arg(ONE + HALF);
    send_arg(-2 * ONE);
    send_arg(32'sh0000_4000);
    send_arg(3 * ONE);
    drain_results();

    // An early step clips and the later steps shrink the value back: the flag must stick.
    c = '{default: '0};
    c[7] = Q_MAX;
    c[6] = Q_MAX;
    load_coefs(c);
    send_arg(q_t'(1));
    send_arg('0);
    drain_results();

    // Random part: a new polynomial per phase, loaded with the pipeline empty.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      random_coefs(c);
      load_coefs(c);
      if (p == RANDOM_PHASES - 1) calm_tail = 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // Once in the middle of a phase the sender waits for the pipeline to run dry.
        if (p == 3 && i == PHASE_ITEMS / 2) drain_results();
        send_arg(pick_value());
      end
      drain_results();
    end

    repeat (PIPE_LATENCY + 4) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/phe_pkg.sv
rtl/phe_arg_if.sv
rtl/phe_res_if.sv
rtl/phe_coef_bank.sv
rtl/phe_cell.sv
rtl/polynomial_horner_evaluator_top.sv
verif/phe_result_checker.sv
verif/polynomial_horner_evaluator_top_test.sv
